/* src/sbms_pkg.sv */
`default_nettype none
package sbms_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 15;
  localparam int MAX_LOG2   = 12;
  localparam int IDX_W      = 12;
  localparam int LOG2_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // shared multiplier: A takes ramp deltas and samples, B steps and factors
  localparam int STEP_W = IDX_W + 1;
  localparam int MA_W   = SAMPLE_W + 2;
  localparam int MB_W   = GAIN_W + 2;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [LOG2_W-1:0] BLOCK_LOG2_RST = LOG2_W'(9);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALANCE,
    CFG_WIDTH,
    CFG_BLOCK
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAMP_B,
    S_RAMP_W,
    S_GAIN,
    S_MID,
    S_SIDE,
    S_MIX,
    S_BAL,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* src/sbms_in_if.sv */
`default_nettype none
interface sbms_in_if;
  logic              valid;
  logic              ready;
  sbms_pkg::sample_t left_in;
  sbms_pkg::sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

/* src/sbms_out_if.sv */
`default_nettype none
interface sbms_out_if;
  logic              valid;
  logic              ready;
  sbms_pkg::sample_t left_out;
  sbms_pkg::sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

/* src/stereo_balance_mid_side.sv */
// Steps per item: two ramp steps, gain, mid, side, mix, balance, output;
//   the result is registered onto out_ch.valid. No new item is taken until
//   the last has left the output step; the single shared 26x18 multiplier
//   is used five times per item (two ramps, mid, side, balance).
// Reset (rst_n low, synchronous): targets 0, block_size_log2 9, ramp state
//   cleared, sequencer idle, no result pending.
`default_nettype none
module stereo_balance_mid_side (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sbms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [sbms_pkg::CFG_DATA_W-1:0] cfg_data,
  sbms_in_if.sink                              in_ch,
  sbms_out_if.source                           out_ch
);

  localparam int SAMPLE_W = sbms_pkg::SAMPLE_W;
  localparam int GAIN_W   = sbms_pkg::GAIN_W;
  localparam int FRAC_W   = sbms_pkg::FRAC_W;
  localparam int IDX_W    = sbms_pkg::IDX_W;
  localparam int LOG2_W   = sbms_pkg::LOG2_W;
  localparam int STEP_W   = sbms_pkg::STEP_W;
  localparam int MA_W     = sbms_pkg::MA_W;
  localparam int MB_W     = sbms_pkg::MB_W;
  localparam int PROD_W   = sbms_pkg::PROD_W;
  localparam int SUM_W    = sbms_pkg::SUM_W;

  // unity gain in Q1.15, held in multiplier B width
  localparam logic signed [MB_W-1:0]  ONE_X    = MB_W'(1) <<< FRAC_W;
  // round-half-up offsets for the mix (>> FRAC+1) and balance (>> FRAC)
  localparam logic signed [SUM_W-1:0] HALF_MIX = SUM_W'(1) <<< FRAC_W;
  localparam logic signed [SUM_W-1:0] HALF_BAL = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI   = (SUM_W'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SAT_LO   = -SAT_HI - 1;
  localparam logic [LOG2_W-1:0]       K_MAX    = LOG2_W'(sbms_pkg::MAX_LOG2);

  function automatic sbms_pkg::sample_t sat(input logic signed [SUM_W-1:0] v);
    sbms_pkg::sample_t res;
    if (v > SAT_HI) begin
      res = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  sbms_pkg::state_t         state_r, state_nxt;

  // config registers
  sbms_pkg::gain_t          bal_tgt_r, bal_tgt_nxt;
  sbms_pkg::gain_t          wid_tgt_r, wid_tgt_nxt;
  logic [LOG2_W-1:0]        blk_log2_r, blk_log2_nxt;

  // ramp state
  sbms_pkg::gain_t          prev_bal_r, prev_bal_nxt;
  sbms_pkg::gain_t          prev_wid_r, prev_wid_nxt;
  logic [IDX_W-1:0]         frame_idx_r, frame_idx_nxt;

  // per-item datapath
  logic signed [SAMPLE_W:0] m2_r, m2_nxt;        // L+R  (2*mid)
  logic signed [SAMPLE_W:0] s2_r, s2_nxt;        // R-L  (2*side)
  logic                     last_r, last_nxt;
  sbms_pkg::gain_t          gb_r, gb_nxt;
  logic                     bal_left_r, bal_left_nxt;  // attenuate left
  logic                     mid_sc_r, mid_sc_nxt;      // scale mid, else side
  logic signed [MB_W-1:0]   fb_r, fb_nxt;
  logic signed [MB_W-1:0]   fw_r, fw_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [MA_W-1:0]   lo_r, lo_nxt;
  logic signed [MA_W-1:0]   ro_r, ro_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  sbms_pkg::sample_t        out_left_r, out_left_nxt;
  sbms_pkg::sample_t        out_right_r, out_right_nxt;

  // ---------------------------------------------------------------------
  // Shared datapath pieces
  // ---------------------------------------------------------------------
  logic [LOG2_W-1:0]        k_eff;
  logic [IDX_W:0]           blk_len;
  logic [IDX_W-1:0]         last_idx;
  logic [STEP_W-1:0]        step;
  logic signed [GAIN_W:0]   dlt_b, dlt_w;
  logic signed [PROD_W-1:0] ramp_q;
  sbms_pkg::gain_t          ramp_g;
  sbms_pkg::gain_t          gw;
  logic signed [MB_W-1:0]   gw_x, gb_x;
  logic signed [SUM_W-1:0]  mix_d, mix_s, bal_s;
  logic signed [SUM_W-1:0]  lo_bal;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     accept;

  assign k_eff    = (blk_log2_r > K_MAX) ? K_MAX : blk_log2_r;
  assign blk_len  = (IDX_W + 1)'(1) << k_eff;
  assign last_idx = IDX_W'(blk_len - 1'b1);
  assign step     = STEP_W'(frame_idx_r) + 1'b1;
  assign dlt_b    = (GAIN_W + 1)'(bal_tgt_r) - (GAIN_W + 1)'(prev_bal_r);
  assign dlt_w    = (GAIN_W + 1)'(wid_tgt_r) - (GAIN_W + 1)'(prev_wid_r);

  // floor(delta*step / 2^k): arithmetic shift; result lies between prev and target
  assign ramp_q   = prod_r >>> k_eff;
  assign ramp_g   = ramp_q[GAIN_W-1:0];

  assign gw       = last_r ? wid_tgt_r : sbms_pkg::gain_t'(prev_wid_r + ramp_g);
  assign gw_x     = MB_W'(gw);
  assign gb_x     = MB_W'(gb_r);

  assign mix_d    = SUM_W'(acc_r) - SUM_W'(prod_r);
  assign mix_s    = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign bal_s    = (SUM_W'(prod_r) + HALF_BAL) >>> FRAC_W;

  assign accept   = in_ch.valid && in_ch.ready;

  assign in_ch.ready      = (state_r == sbms_pkg::S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      sbms_pkg::S_RAMP_B: begin
        mul_a = MA_W'(dlt_b);
        mul_b = signed'(MB_W'(step));
      end
      sbms_pkg::S_RAMP_W: begin
        mul_a = MA_W'(dlt_w);
        mul_b = signed'(MB_W'(step));
      end
      sbms_pkg::S_MID: begin
        mul_a = MA_W'(m2_r);
        mul_b = mid_sc_r ? fw_r : ONE_X;
      end
      sbms_pkg::S_SIDE: begin
        mul_a = MA_W'(s2_r);
        mul_b = mid_sc_r ? ONE_X : fw_r;
      end
      sbms_pkg::S_BAL: begin
        mul_a = bal_left_r ? lo_r : ro_r;
        mul_b = fb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // balance product stays put while the result waits in S_OUT
  assign prod_nxt = (state_r == sbms_pkg::S_OUT) ? prod_r : mul_a * mul_b;

  // sequencer and register updates
  always_comb begin
    state_nxt     = state_r;
    bal_tgt_nxt   = bal_tgt_r;
    wid_tgt_nxt   = wid_tgt_r;
    blk_log2_nxt  = blk_log2_r;
    prev_bal_nxt  = prev_bal_r;
    prev_wid_nxt  = prev_wid_r;
    frame_idx_nxt = frame_idx_r;
    m2_nxt        = m2_r;
    s2_nxt        = s2_r;
    last_nxt      = last_r;
    gb_nxt        = gb_r;
    bal_left_nxt  = bal_left_r;
    mid_sc_nxt    = mid_sc_r;
    fb_nxt        = fb_r;
    fw_nxt        = fw_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    ro_nxt        = ro_r;
    out_valid_nxt = out_valid_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    lo_bal        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (sbms_pkg::cfg_idx_t'(cfg_idx))
        sbms_pkg::CFG_BALANCE: bal_tgt_nxt  = cfg_data[GAIN_W-1:0];
        sbms_pkg::CFG_WIDTH:   wid_tgt_nxt  = cfg_data[GAIN_W-1:0];
        sbms_pkg::CFG_BLOCK:   blk_log2_nxt = cfg_data[LOG2_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      sbms_pkg::S_IDLE: begin
        if (accept) begin
          m2_nxt    = (SAMPLE_W + 1)'(in_ch.left_in) + (SAMPLE_W + 1)'(in_ch.right_in);
          s2_nxt    = (SAMPLE_W + 1)'(in_ch.right_in) - (SAMPLE_W + 1)'(in_ch.left_in);
          state_nxt = sbms_pkg::S_RAMP_B;
        end
      end
      sbms_pkg::S_RAMP_B: begin
        // a shrunk block leaves frame_idx past the end: treat as last frame
        last_nxt  = (frame_idx_r >= last_idx);
        state_nxt = sbms_pkg::S_RAMP_W;
      end
      sbms_pkg::S_RAMP_W: begin
        gb_nxt    = last_r ? bal_tgt_r : sbms_pkg::gain_t'(prev_bal_r + ramp_g);
        state_nxt = sbms_pkg::S_GAIN;
      end
      sbms_pkg::S_GAIN: begin
        mid_sc_nxt   = (gw > 0);
        fw_nxt       = (gw > 0) ? (ONE_X - gw_x) : (ONE_X + gw_x);
        bal_left_nxt = (gb_r > 0);
        fb_nxt       = (gb_r > 0) ? (ONE_X - gb_x) : (ONE_X + gb_x);
        if (last_r) begin
          prev_bal_nxt  = bal_tgt_r;
          prev_wid_nxt  = wid_tgt_r;
          frame_idx_nxt = '0;
        end else begin
          frame_idx_nxt = frame_idx_r + 1'b1;
        end
        state_nxt = sbms_pkg::S_MID;
      end
      sbms_pkg::S_MID: begin
        state_nxt = sbms_pkg::S_SIDE;
      end
      sbms_pkg::S_SIDE: begin
        acc_nxt   = prod_r;  // scaled mid
        state_nxt = sbms_pkg::S_MIX;
      end
      sbms_pkg::S_MIX: begin
        lo_nxt    = MA_W'((mix_d + HALF_MIX) >>> (FRAC_W + 1));
        ro_nxt    = MA_W'((mix_s + HALF_MIX) >>> (FRAC_W + 1));
        state_nxt = sbms_pkg::S_BAL;
      end
      sbms_pkg::S_BAL: begin
        state_nxt = sbms_pkg::S_OUT;
      end
      sbms_pkg::S_OUT: begin
        lo_bal = bal_left_r ? bal_s : SUM_W'(lo_r);
        // hold here until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = sat(lo_bal);
          out_right_nxt = sat(bal_left_r ? SUM_W'(ro_r) : bal_s);
          state_nxt     = sbms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sbms_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbms_pkg::S_IDLE;
      bal_tgt_r   <= '0;
      wid_tgt_r   <= '0;
      blk_log2_r  <= sbms_pkg::BLOCK_LOG2_RST;
      prev_bal_r  <= '0;
      prev_wid_r  <= '0;
      frame_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bal_tgt_r   <= bal_tgt_nxt;
      wid_tgt_r   <= wid_tgt_nxt;
      blk_log2_r  <= blk_log2_nxt;
      prev_bal_r  <= prev_bal_nxt;
      prev_wid_r  <= prev_wid_nxt;
      frame_idx_r <= frame_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m2_r        <= m2_nxt;
    s2_r        <= s2_nxt;
    last_r      <= last_nxt;
    gb_r        <= gb_nxt;
    bal_left_r  <= bal_left_nxt;
    mid_sc_r    <= mid_sc_nxt;
    fb_r        <= fb_nxt;
    fw_r        <= fw_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    lo_r        <= lo_nxt;
    ro_r        <= ro_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sbms_pkg::S_RAMP_B)
    else $error("accepted item did not start the ramp step");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sbms_pkg::S_GAIN && last_r |=> frame_idx_r == '0)
    else $error("frame index not cleared at end of block");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sbms_pkg::S_OUT)
    else $error("result appeared outside the output step");
`endif

endmodule
`default_nettype wire

/* sim/stereo_balance_mid_side_test.sv */
`timescale 1ns / 100ps
module stereo_balance_mid_side_test;

  localparam int SAMPLE_W   = sbms_pkg::SAMPLE_W;
  localparam int GAIN_W     = sbms_pkg::GAIN_W;
  localparam int FRAC_W     = sbms_pkg::FRAC_W;
  localparam int MAX_LOG2   = sbms_pkg::MAX_LOG2;
  localparam int IDX_W      = sbms_pkg::IDX_W;
  localparam int LOG2_W     = sbms_pkg::LOG2_W;
  localparam int CFG_IDX_W  = sbms_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sbms_pkg::CFG_DATA_W;

  typedef sbms_pkg::sample_t sample_t;
  typedef sbms_pkg::gain_t   gain_t;

  // Latency from the accepting edge to the result, when the output does not stall.
  localparam int LATENCY = 8;
  // Index 3 is not decoded by the block; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam int PAD_W = CFG_DATA_W - LOG2_W;

  localparam longint  UNITY      = longint'(1) << FRAC_W;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam gain_t   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam gain_t   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_frame_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbms_in_if  in_ch ();
  sbms_out_if out_ch ();

  stereo_balance_mid_side u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[stereo_balance_mid_side] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state: live registers plus the ramp state of the block.
  // ---------------------------------------------------------------------
  gain_t              bal_target;
  gain_t              wid_target;
  logic [LOG2_W-1:0]  block_log2;
  gain_t              bal_prev;
  gain_t              wid_prev;
  logic [IDX_W-1:0]   frame_pos;

  stereo_frame_t expected_frames[$];
  stereo_frame_t want_frame;
  int            mismatch_count = 0;
  int            frames_out = 0;

  // Traffic shaping, changed per test phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic sample_t clip_sample(input longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  // Works out the output frame for one accepted input frame, queues it and
  // advances the ramp state.
  function automatic void balance_mix_frame(input sample_t l_in, input sample_t r_in);
    int unsigned   k;
    bit            block_end;
    longint        step;
    longint        g_bal;
    longint        g_wid;
    longint        mid2;
    longint        side2;
    longint        f_mid;
    longint        f_side;
    longint        l_mix;
    longint        r_mix;
    stereo_frame_t res;

    // oversized block sizes clamp to the largest block
    k = (block_log2 > MAX_LOG2) ? MAX_LOG2 : block_log2;
    // a position at or past the last frame (block shrunk) ends the block
    block_end = int'(frame_pos) >= (1 << k) - 1;

    if (block_end) begin
      g_bal = bal_target;
      g_wid = wid_target;
    end else begin
      // linear ramp from the previous block's gain, floor division
      step  = longint'(frame_pos) + 1;
      g_bal = longint'(bal_prev) + (((longint'(bal_target) - longint'(bal_prev)) * step) >>> k);
      g_wid = longint'(wid_prev) + (((longint'(wid_target) - longint'(wid_prev)) * step) >>> k);
    end

    // stage one: 2*mid and 2*side, one of them scaled by the width factor
    mid2   = longint'(l_in) + longint'(r_in);
    side2  = longint'(r_in) - longint'(l_in);
    f_mid  = UNITY;
    f_side = UNITY;
    if (g_wid > 0) begin
      f_mid = UNITY - g_wid;
    end else begin
      f_side = UNITY + g_wid;   // -32768 gives a zero factor
    end
    mid2  = mid2 * f_mid;
    side2 = side2 * f_side;
    l_mix = (mid2 - side2 + UNITY) >>> (FRAC_W + 1);
    r_mix = (mid2 + side2 + UNITY) >>> (FRAC_W + 1);

    // stage two: balance attenuates one side, round half up
    if (g_bal > 0) begin
      l_mix = (l_mix * (UNITY - g_bal) + (UNITY >>> 1)) >>> FRAC_W;
    end else begin
      r_mix = (r_mix * (UNITY + g_bal) + (UNITY >>> 1)) >>> FRAC_W;
    end

    if (block_end) begin
      bal_prev  = bal_target;
      wid_prev  = wid_target;
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end

    res.left  = clip_sample(l_mix);
    res.right = clip_sample(r_mix);
    expected_frames.push_back(res);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(int'($urandom_range(64)) - 32);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(9))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return -GAIN_MAX;
      3:       return '0;
      default: return gain_t'($urandom());
    endcase
  endfunction

  // Mostly short blocks so ramps complete often; upper data bits are junk.
  function automatic logic [CFG_DATA_W-1:0] pick_block_data();
    int unsigned k;
    case ($urandom_range(15))
      0:       k = $urandom_range(15, 12);
      1:       k = $urandom_range(8, 5);
      default: k = $urandom_range(4, 0);
    endcase
    return {PAD_W'($urandom()), LOG2_W'(k)};
  endfunction

  // Register write; the predictor copy is updated at the write edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      sbms_pkg::CFG_BALANCE: bal_target = data;
      sbms_pkg::CFG_WIDTH:   wid_target = data;
      sbms_pkg::CFG_BLOCK:   block_log2 = data[LOG2_W-1:0];
      default:     ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one item, with random gaps first. valid stays high on return so
  // back-to-back items never drop it for a step.
  task automatic send_frame(input sample_t l_s, input sample_t r_s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l_s;
    in_ch.right_in <= r_s;
    do @(posedge clk); while (!in_ch.ready);
    balance_mix_frame(l_s, r_s);
  endtask

  // Stops offering and waits for every queued result; with settle set it
  // also lets the pipeline go quiet before registers are touched.
  task automatic drain_results(input bit settle);
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    if (settle) repeat (LATENCY + 4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, plus an explicit hold-off counted here.
  // ---------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      frames_out++;
      if (expected_frames.size() == 0) begin
        if (mismatch_count < 10)
          $display("result %0d arrived with nothing predicted: L=%0d R=%0d",
                   frames_out, out_ch.left_out, out_ch.right_out);
        mismatch_count++;
      end else begin
        want_frame = expected_frames.pop_front();
        if (out_ch.left_out !== want_frame.left || out_ch.right_out !== want_frame.right) begin
          if (mismatch_count < 10)
            $display("result %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                     frames_out, want_frame.left, want_frame.right,
                     out_ch.left_out, out_ch.right_out);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Full-scale and near-zero frames at the extreme gain settings. Block
  // size 0 makes every frame the last of its block, so gains jump straight
  // to the targets.
  task automatic test_directed_extremes();
    // reset settings: 512-frame ramp from zero to zero, i.e. pass-through
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain_results(1'b1);

    write_reg(sbms_pkg::CFG_BLOCK, '0);
    write_reg(sbms_pkg::CFG_BALANCE, GAIN_MAX);   // left almost muted
    write_reg(sbms_pkg::CFG_WIDTH, GAIN_MIN);     // side factor zero: mono
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain_results(1'b1);

    write_reg(sbms_pkg::CFG_BALANCE, GAIN_MIN);   // right fully muted
    write_reg(sbms_pkg::CFG_WIDTH, GAIN_MAX);     // mid almost removed
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain_results(1'b1);

    // smallest nonzero gains, rounding of tiny samples
    write_reg(sbms_pkg::CFG_BALANCE, -gain_t'(1));
    write_reg(sbms_pkg::CFG_WIDTH, gain_t'(1));
    send_frame(sample_t'(1), -sample_t'(1));
    send_frame(-sample_t'(1), sample_t'(0));
    drain_results(1'b1);
  endtask

  // Ramp corner cases: target moved mid-block, block shrunk under the
  // current position, oversized block size, writes to the unused index.
  task automatic test_ramp_corners();
    write_reg(sbms_pkg::CFG_BLOCK, CFG_DATA_W'(MAX_LOG2));
    write_reg(sbms_pkg::CFG_BALANCE, gain_t'(20000));
    write_reg(sbms_pkg::CFG_WIDTH, gain_t'(-12000));
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);

    // ramp must pick up the new target without restarting the block
    write_reg(sbms_pkg::CFG_BALANCE, gain_t'(-30000));
    repeat (2) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);

    // position is now past the last frame of a 4-frame block
    write_reg(sbms_pkg::CFG_BLOCK, CFG_DATA_W'(2));
    repeat (2) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);

    // log2 of 14 with junk in the upper bits behaves as 12
    write_reg(sbms_pkg::CFG_BLOCK, 16'hA5FE);
    write_reg(sbms_pkg::CFG_WIDTH, GAIN_MIN);
    repeat (3) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);

    write_reg(CFG_SPARE, 16'hFFFF);
    repeat (2) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);
  endtask

  // Random frames in bursts; between bursts some registers get new values.
  task automatic test_random_traffic(input int n_frames, input int s_idle, input int r_stall);
    int sent;
    int burst;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    sent = 0;
    while (sent < n_frames) begin
      drain_results(1'b1);
      if ($urandom_range(1)) write_reg(sbms_pkg::CFG_BALANCE, pick_gain());
      if ($urandom_range(1)) write_reg(sbms_pkg::CFG_WIDTH, pick_gain());
      if ($urandom_range(2) == 0) write_reg(sbms_pkg::CFG_BLOCK, pick_block_data());
      if ($urandom_range(9) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
      burst = $urandom_range(60, 8);
      repeat (burst) send_frame(pick_sample(), pick_sample());
      sent += burst;
    end
    drain_results(1'b1);
  endtask

  // Receiver blocks for a long stretch while frames keep coming, so the
  // block backs up into its input; then the sender waits for a full drain
  // mid-ramp and carries on without touching registers.
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results(1'b1);
    write_reg(sbms_pkg::CFG_BLOCK, CFG_DATA_W'(3));
    write_reg(sbms_pkg::CFG_BALANCE, pick_gain());
    write_reg(sbms_pkg::CFG_WIDTH, pick_gain());
    hold_off_cycles = 200;
    repeat (40) send_frame(pick_sample(), pick_sample());
    drain_results(1'b0);
    repeat (20) send_frame(pick_sample(), pick_sample());
    drain_results(1'b1);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;

    bal_target = '0;
    wid_target = '0;
    block_log2 = sbms_pkg::BLOCK_LOG2_RST;
    bal_prev   = '0;
    wid_prev   = '0;
    frame_pos  = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_ramp_corners();
    test_random_traffic(340, 7, 52);
    test_random_traffic(340, 52, 7);
    test_random_traffic(340, 0, 0);
    test_output_stall();

    if (mismatch_count == 0) begin
      $display("[stereo_balance_mid_side] OK");
    end else begin
      $display("[stereo_balance_mid_side] ERROR");
    end
    $finish;
  end

endmodule
